// ===== design/rgb2yuv_pkg.sv =====
// Shared types and constants of the RGB to YUV 4:2:0 converter.
// Holds the controller to datapath command struct, register indexes and
// the fixed-point coefficient helper. Depends on nothing.
`default_nettype none

package rgb2yuv_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int DIM_W       = 13;
  localparam int NUM_STAGES  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd1080;

  // Coefficients given in units of 1e-4.
  localparam int unsigned COEF_RED_E4   = 2126;
  localparam int unsigned COEF_GREEN_E4 = 7152;
  localparam int unsigned COEF_BLUE_E4  = 722;
  localparam int unsigned COEF_U_E4     = 4920;
  localparam int unsigned COEF_V_E4     = 8770;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic                  chroma_valid;
    logic                  frame_end;
  } cmd_t;

  // Round-half-up of e4 / 10000 * 2^frac, worked out at elaboration.
  function automatic longint unsigned coef_q(input int unsigned e4, input int unsigned frac);
    return ((longint'(e4) << frac) + 64'd5000) / 64'd10000;
  endfunction

endpackage

`default_nettype wire

// ===== design/rgb2yuv_ctrl.sv =====
// Controller of the RGB to YUV 4:2:0 converter: handshakes, pipeline
// occupancy, frame position counters, row phase state machine and the
// dimension registers. Depends on rgb2yuv_pkg.
`default_nettype none

module rgb2yuv_ctrl
  import rgb2yuv_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output      cmd_t                   cmd
);

  localparam int CntW  = $clog2(MAX_DIMENSION);
  localparam int LimW  = $clog2(MAX_DIMENSION + 1);
  localparam int ExtW  = (LimW > DIM_W) ? LimW : DIM_W;

  typedef enum logic [1:0] {
    ST_CHROMA_ROW = 2'b01,
    ST_LUMA_ROW   = 2'b10
  } state_t;

  state_t                state, state_next;
  logic [DIM_W-1:0]      frame_width;
  logic [DIM_W-1:0]      frame_height;
  logic [CntW-1:0]       column_count, column_count_next;
  logic [CntW-1:0]       row_count, row_count_next;
  logic [NUM_STAGES-1:0] vld, vld_next;
  logic [NUM_STAGES-1:0] adv;
  logic                  accept;
  logic [ExtW-1:0]       width_used, height_used;
  logic                  row_end, last;

  function automatic logic [ExtW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    if (e < ExtW'(2)) return ExtW'(2);
    if (e > ExtW'(MAX_DIMENSION)) return ExtW'(MAX_DIMENSION);
    return e;
  endfunction

  // A stage may move on when the one after it is empty or is moving on too.
  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign accept    = in_valid && adv[0];
  assign out_valid = vld[NUM_STAGES-1];

  always_comb begin
    vld_next[0] = adv[0] ? accept : vld[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_next[i] = adv[i] ? vld[i-1] : vld[i];
    end
  end

  assign width_used  = clamp_dim(frame_width);
  assign height_used = clamp_dim(frame_height);
  assign row_end     = ExtW'(column_count) >= (width_used - ExtW'(1));
  assign last        = row_end && (ExtW'(row_count) >= (height_used - ExtW'(1)));

  always_comb begin
    cmd.load[0] = accept;
    for (int i = 1; i < NUM_STAGES; i++) begin
      cmd.load[i] = adv[i] && vld[i-1];
    end
    cmd.chroma_valid = (state == ST_CHROMA_ROW) && !column_count[0];
    cmd.frame_end    = last;
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    state_next        = state;
    if (accept) begin
      if (row_end) begin
        column_count_next = '0;
        if (last) begin
          row_count_next = '0;
          state_next     = ST_CHROMA_ROW;
        end else begin
          row_count_next = row_count + CntW'(1);
          unique case (state)
            ST_CHROMA_ROW: state_next = ST_LUMA_ROW;
            ST_LUMA_ROW:   state_next = ST_CHROMA_ROW;
            default:       state_next = ST_CHROMA_ROW;
          endcase
        end
      end else begin
        column_count_next = column_count + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CHROMA_ROW;
      column_count <= '0;
      row_count    <= '0;
      vld          <= '0;
    end else begin
      state        <= state_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      vld          <= vld_next;
    end
  end

  // Writes to indexes beyond the two registers are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[DIM_W-1:0];
      end
      if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data[DIM_W-1:0];
      end
    end
  end

  a_frame_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> (column_count == '0) && (row_count == '0))
    else $error("counters did not return to zero after the frame end beat");

  a_phase_matches_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHROMA_ROW) == !row_count[0])
    else $error("row phase state disagrees with the row counter");

  a_stall_keeps_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> vld[0])
    else $error("first stage lost its item while the input was stalled");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> !in_stall)
    else $error("input stalled although the first stage is empty");

endmodule

`default_nettype wire

// ===== design/rgb2yuv_datapath.sv =====
// Datapath of the RGB to YUV 4:2:0 converter: four registered stages of
// weight products, luma sum and differences, chroma gain products and the
// offset with saturation. Depends on rgb2yuv_pkg.
`default_nettype none

module rgb2yuv_datapath
  import rgb2yuv_pkg::*;
#(
  parameter int COEFF_FRACTION_BITS = 16
) (
  input  wire logic       clk,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  output      logic [7:0] luma,
  output      logic [7:0] chroma_u,
  output      logic [7:0] chroma_v,
  output      logic       chroma_valid,
  output      logic       frame_end
);

  localparam int F   = COEFF_FRACTION_BITS;
  localparam int PW  = F + 8;        // weight product
  localparam int YW  = F + 9;        // luma sum
  localparam int DW  = F + 10;       // signed difference
  localparam int GW  = F + 1;        // signed gain
  localparam int MW  = DW + GW;      // gain product
  localparam int TW  = MW + 1;       // product plus offset

  localparam logic [F-1:0] W_RED   = F'(coef_q(COEF_RED_E4, F));
  localparam logic [F-1:0] W_GREEN = F'(coef_q(COEF_GREEN_E4, F));
  localparam logic [F-1:0] W_BLUE  = F'(coef_q(COEF_BLUE_E4, F));
  localparam logic signed [GW-1:0] GAIN_U = GW'(coef_q(COEF_U_E4, F));
  localparam logic signed [GW-1:0] GAIN_V = GW'(coef_q(COEF_V_E4, F));
  localparam logic signed [TW-1:0] HALF   = TW'(longint'(255) << (2 * F - 1));

  // Stage 0
  logic [PW-1:0] p_red, p_green, p_blue;
  logic [7:0]    red0, blue0;
  logic          cv0, fe0;
  // Stage 1
  logic [YW-1:0]        ysum;
  logic [7:0]           luma_sat;
  logic signed [DW-1:0] diff_u, diff_v;
  logic [7:0]           luma1;
  logic                 cv1, fe1;
  // Stage 2
  logic signed [MW-1:0] prod_u, prod_v;
  logic [7:0]           luma2;
  logic                 cv2, fe2;

  function automatic logic [7:0] sat_chroma(input logic signed [MW-1:0] p);
    logic signed [TW-1:0] total;
    logic signed [TW-1:0] q;
    total = TW'(p) + HALF;
    q     = total >>> (2 * F);
    if (total < 0) return 8'd0;
    if (q > TW'(255)) return 8'd255;
    return q[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load[0]) begin
      p_red   <= PW'(W_RED) * PW'(red);
      p_green <= PW'(W_GREEN) * PW'(green);
      p_blue  <= PW'(W_BLUE) * PW'(blue);
      red0    <= red;
      blue0   <= blue;
      cv0     <= cmd.chroma_valid;
      fe0     <= cmd.frame_end;
    end
  end

  assign ysum     = YW'(p_red) + YW'(p_green) + YW'(p_blue);
  assign luma_sat = ysum[YW-1] ? 8'hFF : ysum[F+7:F];

  always_ff @(posedge clk) begin
    if (cmd.load[1]) begin
      diff_u <= $signed((DW'(blue0) << F) - DW'(ysum));
      diff_v <= $signed((DW'(red0) << F) - DW'(ysum));
      luma1  <= luma_sat;
      cv1    <= cv0;
      fe1    <= fe0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load[2]) begin
      prod_u <= MW'(diff_u) * MW'(GAIN_U);
      prod_v <= MW'(diff_v) * MW'(GAIN_V);
      luma2  <= luma1;
      cv2    <= cv1;
      fe2    <= fe1;
    end
  end

  // Chroma is only meaningful on the top-left pixel of each 2x2 block.
  always_ff @(posedge clk) begin
    if (cmd.load[3]) begin
      luma         <= luma2;
      chroma_u     <= cv2 ? sat_chroma(prod_u) : 8'd0;
      chroma_v     <= cv2 ? sat_chroma(prod_v) : 8'd0;
      chroma_valid <= cv2;
      frame_end    <= fe2;
    end
  end

endmodule

`default_nettype wire

// ===== design/rgb_to_yuv420_converter.sv =====
// RGB to YUV 4:2:0 converter: one luma beat per pixel, chroma on even columns of even rows.
// An accepted input beat reaches its result beat through the four datapath stage registers.
// Throughput is one pixel per cycle, set by the four-stage datapath pipeline whose
// stages move on independently; a waiting result holds off the input only once all
// four stages are full.
// Synchronous reset empties the pipeline, zeroes the column and row counters
// and sets the frame size to 1920 by 1080; no clearing pass is needed.
`default_nettype none

module rgb_to_yuv420_converter
  import rgb2yuv_pkg::*;
#(
  parameter int MAX_DIMENSION       = 4096,
  parameter int COEFF_FRACTION_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire logic [7:0]             red,
  input  wire logic [7:0]             green,
  input  wire logic [7:0]             blue,
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      logic [7:0]             luma,
  output      logic [7:0]             chroma_u,
  output      logic [7:0]             chroma_v,
  output      logic                   chroma_valid,
  output      logic                   frame_end,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t cmd;

  // Register writes are stored at once, so the port never holds off.
  assign cfg_ready = 1'b1;

  rgb2yuv_ctrl #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd)
  );

  rgb2yuv_datapath #(
    .COEFF_FRACTION_BITS(COEFF_FRACTION_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .luma        (luma),
    .chroma_u    (chroma_u),
    .chroma_v    (chroma_v),
    .chroma_valid(chroma_valid),
    .frame_end   (frame_end)
  );

endmodule

`default_nettype wire
